>>> design/rrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrs_pkg;

  localparam int RECORD_BYTES_DEF = 64;
  localparam int COPIES_DEF       = 4;

  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 6;
  localparam int BYTE_W     = 8;
  localparam int COPY_IDX_W = 3;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_STAGE_WR = 2'd0,
    ACT_STAGE_RD = 2'd1,
    ACT_LOAD     = 2'd2,
    ACT_SAVE     = 2'd3
  } action_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     read_byte;
    logic                  found;
    logic [COPY_IDX_W-1:0] copy_index;
  } resp_t;

endpackage
`default_nettype wire

>>> design/redundant_record_store_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Each result may wait for out_ready. Throughput: one word at a time, single store port.
// Load: scan the copies in order, fetch the first valid one into staging and rewrite
//   copies from it. Save: write copies from staging. Reset: synchronous, active low;
//   an erase sweep fills the store with 0xFF and zeroes staging.
module redundant_record_store_top #(
  parameter  int RECORD_BYTES = rrs_pkg::RECORD_BYTES_DEF,
  parameter  int COPIES       = rrs_pkg::COPIES_DEF,
  localparam int STORE        = COPIES * (RECORD_BYTES + 2),
  localparam int AW           = $clog2(STORE),
  localparam int SAW          = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rrs_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [rrs_pkg::INDEX_W-1:0]    in_byte_index,
  input  wire logic [rrs_pkg::BYTE_W-1:0]     in_byte_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [rrs_pkg::BYTE_W-1:0]     out_read_byte,
  output logic                                out_found,
  output logic      [rrs_pkg::COPY_IDX_W-1:0] out_copy_index
);
  import rrs_pkg::*;

  // Sequencer to output register
  logic              resp_valid;
  logic              resp_ready;
  resp_t             resp;

  // Copy store port
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [BYTE_W-1:0] st_wdata;
  logic [AW-1:0]     st_raddr;
  logic [BYTE_W-1:0] st_rdata;

  // Staging record port
  logic              stg_we;
  logic [SAW-1:0]    stg_waddr;
  logic [BYTE_W-1:0] stg_wdata;
  logic [SAW-1:0]    stg_raddr;
  logic [BYTE_W-1:0] stg_rdata;

  logic              out_valid_r;
  resp_t             out_word_r;

  // All copies with their check bytes, back to back
  rrs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Working record
  rrs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RECORD_BYTES)
  ) u_staging (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (stg_wdata),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  rrs_ctrl #(
    .RECORD_BYTES (RECORD_BYTES),
    .COPIES       (COPIES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_index (in_byte_index),
    .in_byte_value (in_byte_value),
    .resp_valid    (resp_valid),
    .resp_ready    (resp_ready),
    .resp          (resp),
    .st_we         (st_we),
    .st_waddr      (st_waddr),
    .st_wdata      (st_wdata),
    .st_raddr      (st_raddr),
    .st_rdata      (st_rdata),
    .stg_we        (stg_we),
    .stg_waddr     (stg_waddr),
    .stg_wdata     (stg_wdata),
    .stg_raddr     (stg_raddr),
    .stg_rdata     (stg_rdata)
  );

  // Take a new result word whenever the output register is empty or being drained
  assign resp_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (resp_valid && resp_ready) begin
        out_valid_r <= 1'b1;
        out_word_r  <= resp;
      end else if (out_ready) begin
        // drop the word once taken
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_byte  = out_word_r.read_byte;
  assign out_found      = out_word_r.found;
  assign out_copy_index = out_word_r.copy_index;

endmodule
`default_nettype wire

>>> design/rrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rrs_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/rrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rrs_ctrl #(
  parameter  int RECORD_BYTES = rrs_pkg::RECORD_BYTES_DEF,
  parameter  int COPIES       = rrs_pkg::COPIES_DEF,
  localparam int SLOT         = RECORD_BYTES + 2,
  localparam int STORE        = COPIES * SLOT,
  localparam int AW           = $clog2(STORE),
  localparam int SAW          = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rrs_pkg::ACTION_W-1:0] in_action,
  input  wire logic [rrs_pkg::INDEX_W-1:0]  in_byte_index,
  input  wire logic [rrs_pkg::BYTE_W-1:0]   in_byte_value,
  output logic                              resp_valid,
  input  wire logic                         resp_ready,
  output rrs_pkg::resp_t                    resp,
  output logic                              st_we,
  output logic      [AW-1:0]                st_waddr,
  output logic      [rrs_pkg::BYTE_W-1:0]   st_wdata,
  output logic      [AW-1:0]                st_raddr,
  input  wire logic [rrs_pkg::BYTE_W-1:0]   st_rdata,
  output logic                              stg_we,
  output logic      [SAW-1:0]               stg_waddr,
  output logic      [rrs_pkg::BYTE_W-1:0]   stg_wdata,
  output logic      [SAW-1:0]               stg_raddr,
  input  wire logic [rrs_pkg::BYTE_W-1:0]   stg_rdata
);
  import rrs_pkg::*;

  localparam int PW = $clog2(RECORD_BYTES + 2);
  localparam int KW = $clog2(COPIES + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SREAD, S_SCAN, S_COPY, S_PUT, S_RESP
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     clr_r;
  logic [PW-1:0]     ipos_r;
  logic              iss_r;
  logic [PW-1:0]     ppos_r;
  logic              pv_r;
  logic [AW-1:0]     base_r;
  logic [KW-1:0]     k_r;
  logic [KW-1:0]     lim_r;
  logic [BYTE_W-1:0] ca_r;
  logic [BYTE_W-1:0] cb_r;
  logic              cka_r;
  logic [KW-1:0]     cur_k_r;
  logic              cur_inv_r;
  logic              rd_ok_r;
  resp_t             resp_r;

  logic              accept;
  logic              idx_ok;
  logic [BYTE_W-1:0] d_sel;
  logic [PW-1:0]     ipos_last;
  logic              at_rec_end;
  logic              at_slot_end;
  logic              good;
  logic              clr_in_rec;
  logic [KW+1:0]     save_sum;
  logic [KW+1:0]     hit_sum;
  logic [KW-1:0]     save_lim;
  logic [KW-1:0]     hit_lim;
  action_t           act;

  assign act         = action_t'(in_action);
  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign idx_ok      = {2'b00, in_byte_index} < 8'(RECORD_BYTES);
  assign resp_valid  = (state_r == S_RESP);
  assign resp        = resp_r;

  assign d_sel       = (state_r == S_PUT) ? stg_rdata : st_rdata;
  assign ipos_last   = (state_r == S_COPY) ? PW'(RECORD_BYTES - 1) : PW'(RECORD_BYTES + 1);
  assign at_rec_end  = pv_r && (ppos_r == PW'(RECORD_BYTES - 1));
  assign at_slot_end = pv_r && (ppos_r == PW'(RECORD_BYTES + 1));
  assign good        = cka_r && (cb_r == st_rdata);
  assign clr_in_rec  = clr_r < AW'(RECORD_BYTES);

  // Repair: leading copies to cursor+2, capped at COPIES; all on an invalid cursor
  assign save_sum = {2'b00, cur_k_r} + (KW + 2)'(2);
  assign hit_sum  = {2'b00, k_r} + (KW + 2)'(2);
  assign save_lim = (cur_inv_r || save_sum > (KW + 2)'(COPIES)) ? KW'(COPIES)
                                                                  : save_sum[KW-1:0];
  assign hit_lim  = (hit_sum > (KW + 2)'(COPIES)) ? KW'(COPIES) : hit_sum[KW-1:0];

  // Store port: erase sweep, or write back staging bytes and check bytes
  always_comb begin
    st_raddr = base_r + AW'(ipos_r);
    st_we    = 1'b0;
    st_waddr = base_r + AW'(ppos_r);
    st_wdata = stg_rdata;
    if (state_r == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_r;
      st_wdata = ERASED_BYTE;
    end else if (state_r == S_PUT && pv_r) begin
      st_we = 1'b1;
      if (ppos_r == PW'(RECORD_BYTES)) begin
        st_wdata = ca_r;
      end else if (ppos_r == PW'(RECORD_BYTES + 1)) begin
        st_wdata = cb_r;
      end
    end
  end

  // Staging port: host write, copy from a valid copy, or zero sweep
  always_comb begin
    stg_raddr = (state_r == S_PUT) ? SAW'(ipos_r) : SAW'(in_byte_index);
    stg_we    = 1'b0;
    stg_waddr = SAW'(in_byte_index);
    stg_wdata = in_byte_value;
    if (state_r == S_CLEAR) begin
      stg_we    = clr_in_rec;
      stg_waddr = SAW'(clr_r);
      stg_wdata = '0;
    end else if (state_r == S_COPY) begin
      stg_we    = pv_r;
      stg_waddr = SAW'(ppos_r);
      stg_wdata = st_rdata;
    end else if (accept && act == ACT_STAGE_WR) begin
      stg_we = idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      iss_r     <= 1'b0;
      pv_r      <= 1'b0;
      cur_k_r   <= '0;
      cur_inv_r <= 1'b0;
    end else begin
      pv_r   <= iss_r;
      ppos_r <= ipos_r;
      if (iss_r) begin
        ipos_r <= ipos_r + PW'(1);
        if (ipos_r == ipos_last) begin
          iss_r <= 1'b0;
        end
      end
      if ((state_r == S_SCAN || state_r == S_PUT) && pv_r &&
          ppos_r < PW'(RECORD_BYTES)) begin
        ca_r <= ca_r + d_sel;
        cb_r <= cb_r + ca_r + d_sel;
      end
      if (state_r == S_SCAN && pv_r && ppos_r == PW'(RECORD_BYTES)) begin
        cka_r <= (ca_r == st_rdata);
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(STORE - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            resp_r  <= '0;
            base_r  <= '0;
            k_r     <= KW'(1);
            ca_r    <= '0;
            cb_r    <= '0;
            rd_ok_r <= idx_ok;
            unique case (act)
              ACT_STAGE_WR: state_r <= S_RESP;
              ACT_STAGE_RD: state_r <= S_SREAD;
              ACT_LOAD: begin
                ipos_r  <= '0;
                iss_r   <= 1'b1;
                state_r <= S_SCAN;
              end
              ACT_SAVE: begin
                ipos_r  <= '0;
                iss_r   <= 1'b1;
                lim_r   <= save_lim;
                state_r <= S_PUT;
              end
              default: state_r <= S_RESP;
            endcase
          end
        end
        S_SREAD: begin
          resp_r.read_byte <= rd_ok_r ? stg_rdata : '0;
          state_r          <= S_RESP;
        end
        S_SCAN: begin
          if (at_slot_end) begin
            ipos_r <= '0;
            iss_r  <= 1'b1;
            ca_r   <= '0;
            cb_r   <= '0;
            if (good) begin
              cur_k_r           <= k_r;
              cur_inv_r         <= 1'b0;
              resp_r.found      <= 1'b1;
              resp_r.copy_index <= COPY_IDX_W'(k_r);
              lim_r             <= hit_lim;
              state_r           <= S_COPY;
            end else if (k_r == KW'(COPIES)) begin
              cur_inv_r <= 1'b1;
              lim_r     <= KW'(COPIES);
              base_r    <= '0;
              k_r       <= KW'(1);
              state_r   <= S_PUT;
            end else begin
              k_r    <= k_r + KW'(1);
              base_r <= base_r + AW'(SLOT);
            end
          end
        end
        S_COPY: begin
          if (at_rec_end) begin
            if (k_r != KW'(1)) begin
              base_r  <= '0;
              k_r     <= KW'(1);
              ipos_r  <= '0;
              iss_r   <= 1'b1;
              ca_r    <= '0;
              cb_r    <= '0;
              state_r <= S_PUT;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_PUT: begin
          if (at_slot_end) begin
            if (k_r == lim_r) begin
              state_r <= S_RESP;
            end else begin
              k_r    <= k_r + KW'(1);
              base_r <= base_r + AW'(SLOT);
              ipos_r <= '0;
              iss_r  <= 1'b1;
              ca_r   <= '0;
              cb_r   <= '0;
            end
          end
        end
        S_RESP: begin
          if (resp_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_pv_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_SCAN || state_r == S_COPY || state_r == S_PUT))
    else $error("returned data outside a store walk");

  a_found_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && resp_r.found) |-> (!cur_inv_r && cur_k_r != '0))
    else $error("found result without a valid cursor");

  a_miss_rewrites_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && at_slot_end && !good && k_r == KW'(COPIES)) |=>
      (state_r == S_PUT && lim_r == KW'(COPIES) && k_r == KW'(1) && cur_inv_r))
    else $error("scan miss did not start a full rewrite");

  a_store_addr: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (st_waddr <= AW'(STORE - 1)))
    else $error("store write beyond the last copy");

endmodule
`default_nettype wire

>>> tb/rrs_checker.sv
`timescale 1ns / 1ps
module rrs_checker #(
  parameter int RECORD_BYTES = rrs_pkg::RECORD_BYTES_DEF,
  parameter int COPIES       = rrs_pkg::COPIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [rrs_pkg::ACTION_W-1:0]   in_action,
  input  logic [rrs_pkg::INDEX_W-1:0]    in_byte_index,
  input  logic [rrs_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [rrs_pkg::BYTE_W-1:0]     out_read_byte,
  input  logic                           out_found,
  input  logic [rrs_pkg::COPY_IDX_W-1:0] out_copy_index,
  output int                             fail_count,
  output int                             pending,
  output int                             words_checked,
  output int                             loads_hit,
  output int                             loads_missed,
  output int                             saves_done
);
  import rrs_pkg::*;

  localparam int         SLOT_BYTES  = RECORD_BYTES + 2;
  localparam int         STORE_BYTES = COPIES * SLOT_BYTES;
  localparam logic [7:0] CURSOR_NONE = 8'hFF;

  logic [BYTE_W-1:0] mirror_store [STORE_BYTES];
  logic [BYTE_W-1:0] mirror_stage [RECORD_BYTES];
  logic [7:0]        mirror_cursor;
  resp_t             awaited_words [$];

  // Write staging plus both check bytes into copy k (one-based).
  function automatic void store_copy(int k);
    int base;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    base  = (k - 1) * SLOT_BYTES;
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < RECORD_BYTES; i++) begin
      mirror_store[base + i] = mirror_stage[i];
      sum_a = sum_a + mirror_stage[i];
      sum_b = sum_b + sum_a;
    end
    mirror_store[base + RECORD_BYTES]     = sum_a;
    mirror_store[base + RECORD_BYTES + 1] = sum_b;
  endfunction

  function automatic bit copy_intact(int k);
    int base;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    base  = (k - 1) * SLOT_BYTES;
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < RECORD_BYTES; i++) begin
      sum_a = sum_a + mirror_store[base + i];
      sum_b = sum_b + sum_a;
    end
    return (sum_a == mirror_store[base + RECORD_BYTES]) &&
           (sum_b == mirror_store[base + RECORD_BYTES + 1]);
  endfunction

  function automatic void store_leading(int upto);
    int last;
    last = (upto > COPIES) ? COPIES : upto;
    for (int k = 1; k <= last; k++) store_copy(k);
  endfunction

  // Advance the mirror by one accepted word and return the result it owes.
  function automatic resp_t record_word(logic [ACTION_W-1:0] act,
                                        logic [INDEX_W-1:0] idx,
                                        logic [BYTE_W-1:0] val);
    resp_t r;
    int    hit;
    r   = '0;
    hit = 0;
    case (action_t'(act))
      ACT_STAGE_WR: begin
        if (idx < RECORD_BYTES) mirror_stage[idx] = val;
      end
      ACT_STAGE_RD: begin
        if (idx < RECORD_BYTES) r.read_byte = mirror_stage[idx];
      end
      ACT_LOAD: begin
        for (int k = 1; k <= COPIES && hit == 0; k++) begin
          if (copy_intact(k)) hit = k;
        end
        if (hit != 0) begin
          for (int i = 0; i < RECORD_BYTES; i++)
            mirror_stage[i] = mirror_store[(hit - 1) * SLOT_BYTES + i];
          mirror_cursor = 8'(hit);
          if (hit > 1) store_leading(hit + 2);
          r.found      = 1'b1;
          r.copy_index = COPY_IDX_W'(hit);
          loads_hit++;
        end else begin
          store_leading(COPIES);
          mirror_cursor = CURSOR_NONE;
          loads_missed++;
        end
      end
      default: begin
        if (mirror_cursor == CURSOR_NONE) store_leading(COPIES);
        else store_leading(int'(mirror_cursor) + 2);
        saves_done++;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (!rst_n) begin
      foreach (mirror_store[i]) mirror_store[i] = ERASED_BYTE;
      foreach (mirror_stage[i]) mirror_stage[i] = '0;
      mirror_cursor = '0;
      awaited_words.delete();
    end else begin
      // check the outgoing word before queueing the incoming one
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word read_byte=%02h found=%0b copy_index=%0d",
                   $time, out_read_byte, out_found, out_copy_index);
        end else begin
          want = awaited_words.pop_front();
          words_checked++;
          if (out_read_byte !== want.read_byte) begin
            fail_count++;
            $display("%0t: read_byte expected %02h actual %02h",
                     $time, want.read_byte, out_read_byte);
          end
          if (out_found !== want.found) begin
            fail_count++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, out_found);
          end
          if (out_copy_index !== want.copy_index) begin
            fail_count++;
            $display("%0t: copy_index expected %0d actual %0d",
                     $time, want.copy_index, out_copy_index);
          end
        end
      end
      if (in_valid && in_ready)
        awaited_words.push_back(record_word(in_action, in_byte_index, in_byte_value));
    end
    pending <= awaited_words.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import rrs_pkg::*;

  // This bound lies far above what WORD_TOTAL words with stalls take, so it only trips on a hang.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int WORD_TOTAL   = 1130;
  localparam int HOLD_AT      = 5000;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 600;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [ACTION_W-1:0]   in_action;
  logic [INDEX_W-1:0]    in_byte_index;
  logic [BYTE_W-1:0]     in_byte_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [BYTE_W-1:0]     out_read_byte;
  logic                  out_found;
  logic [COPY_IDX_W-1:0] out_copy_index;

  int tx_idle_pct;
  int rx_idle_pct;
  int sent_words;
  int cycle_count;
  int fail_count;
  int pending;
  int words_checked;
  int loads_hit;
  int loads_missed;
  int saves_done;

  redundant_record_store_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_index (in_byte_index),
    .in_byte_value (in_byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_byte (out_read_byte),
    .out_found     (out_found),
    .out_copy_index(out_copy_index)
  );

  rrs_checker u_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_index (in_byte_index),
    .in_byte_value (in_byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_byte (out_read_byte),
    .out_found     (out_found),
    .out_copy_index(out_copy_index),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .loads_hit     (loads_hit),
    .loads_missed  (loads_missed),
    .saves_done    (saves_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hang guard: count every edge and give up at the limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still awaited", cycle_count, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off counted here, so that
  // the block's result register fills and in_ready drops while words keep coming.
  initial begin
    int since_reset;
    int hold_left;
    since_reset = 0;
    hold_left   = 0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n) since_reset++;
      if (since_reset == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one word from a falling edge; idle first at the sender's rate, then hold
  // valid and payload until the handshake, and return on the next falling edge.
  task automatic send_word(action_t act, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_byte_index <= idx;
    in_byte_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  initial begin
    int     pick;
    bit     save_first;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_STAGE_WR;
    in_byte_index = '0;
    in_byte_value = '0;
    tx_idle_pct   = 15;
    rx_idle_pct   = 49;
    sent_words    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Staging starts zeroed: read both ends, then write the extremes and
    // alternating bit patterns and read them back.
    send_word(ACT_STAGE_RD, 6'd0, 8'h00);
    send_word(ACT_STAGE_RD, 6'd63, 8'h00);
    send_word(ACT_STAGE_WR, 6'd0, 8'hFF);
    send_word(ACT_STAGE_WR, 6'd63, 8'h00);
    send_word(ACT_STAGE_WR, 6'd21, 8'hAA);
    send_word(ACT_STAGE_WR, 6'd42, 8'h55);
    send_word(ACT_STAGE_WR, 6'd62, 8'hFF);
    send_word(ACT_STAGE_RD, 6'd0, 8'h00);
    send_word(ACT_STAGE_RD, 6'd63, 8'h00);
    send_word(ACT_STAGE_RD, 6'd21, 8'h00);
    send_word(ACT_STAGE_RD, 6'd42, 8'h00);

    // Once any copy is written, copy 1 stays valid for good, so a save before the
    // first load and a load over a fully erased store cannot share one run: let
    // the seed pick which of the two opens the store.
    save_first = $urandom_range(1);
    if (save_first) begin
      send_word(ACT_SAVE, 6'd0, 8'h00);
      send_word(ACT_LOAD, 6'd0, 8'h00);
    end else begin
      send_word(ACT_LOAD, 6'd0, 8'h00);
      send_word(ACT_SAVE, 6'd0, 8'h00);
    end
    send_word(ACT_LOAD, 6'd0, 8'h00);
    send_word(ACT_SAVE, 6'd0, 8'h00);
    send_word(ACT_STAGE_WR, 6'd5, 8'h3C);
    send_word(ACT_SAVE, 6'd0, 8'h00);
    send_word(ACT_STAGE_WR, 6'd5, 8'hC3);
    send_word(ACT_LOAD, 6'd0, 8'h00);
    send_word(ACT_STAGE_RD, 6'd5, 8'h00);
    send_word(ACT_STAGE_RD, 6'd62, 8'h00);

    // Random words: mostly staging traffic, with enough loads and saves to keep
    // the copies churning. Swap the idle rates at a third, drop them at two thirds.
    while (sent_words < WORD_TOTAL) begin
      if (sent_words == WORD_TOTAL / 3) begin
        tx_idle_pct <= 49;
        rx_idle_pct <= 15;
      end else if (sent_words == 2 * WORD_TOTAL / 3) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      pick = $urandom_range(99);
      if (pick < 45)
        send_word(ACT_STAGE_WR, INDEX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
      else if (pick < 80)
        send_word(ACT_STAGE_RD, INDEX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
      else if (pick < 90)
        send_word(ACT_LOAD, INDEX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
      else
        send_word(ACT_SAVE, INDEX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
    end
    in_valid <= 1'b0;

    // Drain: wait for every awaited word, then linger to catch strays.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words, checked %0d results in %0d cycles.",
             sent_words, words_checked, cycle_count);
    $display("Loads with a valid copy %0d, loads over no valid copy %0d, saves %0d.",
             loads_hit, loads_missed, saves_done);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rrs_pkg.sv
design/rrs_ram.sv
design/rrs_ctrl.sv
design/redundant_record_store_top.sv
tb/rrs_checker.sv
tb/tb.sv
